FILE: design/hdtlp_pkg.sv
`default_nettype none

package hdtlp_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int OUT_TDATA_W = 88;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_DIG9   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;

  localparam logic [9:0] TEXT_CNT_MAX = 10'h3FF;

  typedef enum logic [2:0] {
    PH_START,
    PH_LEAD,
    PH_OFS,
    PH_WS1,
    PH_ID,
    PH_WS2,
    PH_TEXT,
    PH_DROP
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SKIP    = 3'd1,
    ST_BADOFS  = 3'd2,
    ST_BADID   = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  typedef enum logic {
    KIND_TEXT   = 1'b0,
    KIND_RECORD = 1'b1
  } kind_t;

  // One queue entry carries every result of one input beat: an optional
  // leading text byte and a final result that always closes the beat.
  typedef struct packed {
    logic        lead_v;
    logic [7:0]  lead_byte;
    kind_t       kind;
    logic [7:0]  text_byte;
    logic [31:0] line_offset;
    logic [31:0] voice_number;
    logic [9:0]  text_length;
    status_t     status;
  } hdtlp_entry_t;

endpackage

`default_nettype wire

FILE: design/hdtlp_front.sv
`default_nettype none

module hdtlp_front #(
  parameter int MAX_LINE = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,
  input  logic                    cfg_tvalid,
  output logic                    cfg_tready,
  input  logic [31:0]             cfg_tdata,
  input  logic                    q_full,
  output logic                    push,
  output hdtlp_pkg::hdtlp_entry_t push_entry
);
  import hdtlp_pkg::*;

  localparam int LB_W = $clog2(MAX_LINE);
  localparam logic [LB_W-1:0] LINE_LIM = LB_W'(MAX_LINE - 1);

  phase_t          phase_r, phase_nxt, p;
  status_t         line_status_r, line_status_nxt, st;
  logic [31:0]     offset_acc_r, offset_acc_nxt;
  logic [31:0]     id_acc_r, id_acc_nxt;
  logic [9:0]      text_count_r, text_count_nxt, rec_cnt;
  logic            bs_pend_r, bs_pend_nxt;
  logic [LB_W-1:0] line_bytes_r, line_bytes_nxt;
  logic [31:0]     inv_ofs_r;
  logic            acc, stop, is_ws, is_dig;
  logic [4:0]      hexv;
  logic [1:0]      n_emit;
  logic [7:0]      b0, b1, c;
  hdtlp_entry_t    ent;

  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [4:0] r;
    r = '0;
    if (ch >= CH_DIG0 && ch <= CH_DIG9) begin
      r = {1'b1, 4'(ch - CH_DIG0)};
    end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
      r = {1'b1, 4'(ch - CH_UP_A + 8'd10)};
    end else if (ch >= CH_LOW_A && ch <= CH_LOW_F) begin
      r = {1'b1, 4'(ch - CH_LOW_A + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic [9:0] sat_add(input logic [9:0] a, input logic [1:0] n);
    logic [10:0] s;
    s = {1'b0, a} + 11'(n);
    return s[10] ? TEXT_CNT_MAX : s[9:0];
  endfunction

  assign in_tready  = !q_full;
  assign cfg_tready = 1'b1;
  assign acc        = in_tvalid && in_tready;
  assign c          = in_tdata;
  assign is_ws      = (c == CH_SPACE) || (c == CH_TAB);
  assign is_dig     = (c >= CH_DIG0) && (c <= CH_DIG9);
  assign hexv       = hex_decode(c);

  always_comb begin
    phase_nxt       = phase_r;
    line_status_nxt = line_status_r;
    offset_acc_nxt  = offset_acc_r;
    id_acc_nxt      = id_acc_r;
    text_count_nxt  = text_count_r;
    bs_pend_nxt     = bs_pend_r;
    line_bytes_nxt  = line_bytes_r;
    p               = phase_r;
    st              = ST_OK;
    rec_cnt         = text_count_r;
    stop            = 1'b0;
    n_emit          = 2'd0;
    b0              = CH_NUL;
    b1              = CH_NUL;
    push            = 1'b0;
    ent             = '0;

    if (acc && c == CH_NUL) begin
      push = 1'b1;
      unique case (phase_r) inside
        PH_START:         st = ST_SKIP;
        PH_LEAD, PH_OFS:  st = ST_BADOFS;
        PH_WS1:           st = ST_BADID;
        PH_ID:            st = (offset_acc_r == inv_ofs_r) ? ST_INVALID : ST_OK;
        PH_WS2, PH_TEXT: begin
          st = ST_OK;
          if (bs_pend_r) begin
            ent.lead_v    = 1'b1;
            ent.lead_byte = CH_BSLASH;
            rec_cnt       = sat_add(text_count_r, 2'd1);
          end
        end
        default:          st = line_status_r;
      endcase
      ent.kind   = KIND_RECORD;
      ent.status = st;
      if (st == ST_OK || st == ST_INVALID) begin
        ent.line_offset  = offset_acc_r;
        ent.voice_number = id_acc_r;
      end
      if (st == ST_OK) begin
        ent.text_length = rec_cnt;
      end
      phase_nxt       = PH_START;
      line_status_nxt = ST_OK;
      offset_acc_nxt  = '0;
      id_acc_nxt      = '0;
      text_count_nxt  = '0;
      bs_pend_nxt     = 1'b0;
      line_bytes_nxt  = '0;
    end else if (acc && line_bytes_r < LINE_LIM) begin
      line_bytes_nxt = line_bytes_r + 1'b1;
      if (p == PH_START) begin
        if (c == CH_HASH || c == CH_SEMI) begin
          line_status_nxt = ST_SKIP;
          p               = PH_DROP;
          stop            = 1'b1;
        end else begin
          p = PH_LEAD;
        end
      end
      if (!stop && p == PH_LEAD) begin
        if (is_ws) begin
          stop = 1'b1;
        end else begin
          p = PH_OFS;
        end
      end
      if (!stop && p == PH_OFS) begin
        stop = 1'b1;
        if (is_ws) begin
          p = PH_WS1;
        end else if (hexv[4]) begin
          offset_acc_nxt = {offset_acc_r[27:0], hexv[3:0]};
        end else begin
          line_status_nxt = ST_BADOFS;
          p               = PH_DROP;
        end
      end
      if (!stop && p == PH_WS1) begin
        if (is_ws) begin
          stop = 1'b1;
        end else begin
          p = PH_ID;
        end
      end
      if (!stop && p == PH_ID) begin
        stop = 1'b1;
        if (is_ws) begin
          if (offset_acc_r == inv_ofs_r) begin
            line_status_nxt = ST_INVALID;
            p               = PH_DROP;
          end else begin
            p = PH_WS2;
          end
        end else if (is_dig) begin
          id_acc_nxt = (id_acc_r << 3) + (id_acc_r << 1) + 32'(c - CH_DIG0);
        end else begin
          line_status_nxt = ST_BADID;
          p               = PH_DROP;
        end
      end
      if (!stop && p == PH_WS2) begin
        if (is_ws) begin
          stop = 1'b1;
        end else begin
          p = PH_TEXT;
        end
      end
      if (!stop && p == PH_TEXT) begin
        if (bs_pend_r) begin
          bs_pend_nxt = 1'b0;
          if (c == CH_LOW_N) begin
            b0     = CH_NL;
            n_emit = 2'd1;
          end else if (c == CH_BSLASH) begin
            b0          = CH_BSLASH;
            n_emit      = 2'd1;
            bs_pend_nxt = 1'b1;
          end else begin
            b0     = CH_BSLASH;
            b1     = c;
            n_emit = 2'd2;
          end
        end else if (c == CH_BSLASH) begin
          bs_pend_nxt = 1'b1;
        end else begin
          b0     = c;
          n_emit = 2'd1;
        end
      end
      phase_nxt      = p;
      text_count_nxt = sat_add(text_count_r, n_emit);
      ent.kind       = KIND_TEXT;
      if (n_emit == 2'd2) begin
        push          = 1'b1;
        ent.lead_v    = 1'b1;
        ent.lead_byte = b0;
        ent.text_byte = b1;
      end else if (n_emit == 2'd1) begin
        push          = 1'b1;
        ent.text_byte = b0;
      end
    end
  end

  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_START;
      line_status_r <= ST_OK;
      offset_acc_r  <= '0;
      id_acc_r      <= '0;
      text_count_r  <= '0;
      bs_pend_r     <= 1'b0;
      line_bytes_r  <= '0;
      inv_ofs_r     <= '0;
    end else begin
      phase_r       <= phase_nxt;
      line_status_r <= line_status_nxt;
      offset_acc_r  <= offset_acc_nxt;
      id_acc_r      <= id_acc_nxt;
      text_count_r  <= text_count_nxt;
      bs_pend_r     <= bs_pend_nxt;
      line_bytes_r  <= line_bytes_nxt;
      if (cfg_tvalid && cfg_tready) begin
        inv_ofs_r <= cfg_tdata;
      end
    end
  end

  // A beat that ends a line always produces its record.
  a_eol_push: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && c == CH_NUL) |-> (push && push_entry.kind == KIND_RECORD))
    else $error("end of line did not produce a record");

endmodule

`default_nettype wire

FILE: design/hdtlp_queue.sv
`default_nettype none

module hdtlp_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  hdtlp_pkg::hdtlp_entry_t push_entry,
  output logic                    full,
  input  logic                    pop,
  output logic                    empty,
  output hdtlp_pkg::hdtlp_entry_t head
);
  import hdtlp_pkg::*;

  hdtlp_entry_t      slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

FILE: design/hdtlp_back.sv
`default_nettype none

module hdtlp_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  hdtlp_pkg::hdtlp_entry_t        head,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [hdtlp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tuser,
  output logic                           out_tlast
);
  import hdtlp_pkg::*;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_user_r, out_user_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   lead_done_r, lead_done_nxt;
  logic                   load_ok;

  assign load_ok = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    lead_done_nxt = lead_done_r;
    pop           = 1'b0;
    if (load_ok) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        if (head.lead_v && !lead_done_r) begin
          out_data_nxt  = {(OUT_TDATA_W - 8)'(0), head.lead_byte};
          out_user_nxt  = KIND_TEXT;
          out_last_nxt  = 1'b0;
          lead_done_nxt = 1'b1;
        end else begin
          out_data_nxt  = {3'b000, head.status, head.text_length, head.voice_number,
                           head.line_offset, head.text_byte};
          out_user_nxt  = head.kind;
          out_last_nxt  = 1'b1;
          lead_done_nxt = 1'b0;
          pop           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      lead_done_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      lead_done_r <= lead_done_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  a_pop_loads_final: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_tvalid && out_tlast))
    else $error("retired entry did not load its final beat");

  a_lead_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> lead_done_r)
    else $error("leading beat shown without its entry held");

endmodule

`default_nettype wire

FILE: design/hex_dec_text_line_parser.sv
// Table-line text parser. Bytes of a table file enter on the in_ channel,
// one per beat, and a zero byte ends each line. Each line yields the
// translated text bytes of an accepted line (out_tuser low) and then one
// end-of-line record (out_tuser high) with offset, id, text length and
// status. out_tlast marks the final result caused by one input beat.
// The cfg_ channel writes the invalid offset and is always ready; it is
// to be written only while the block is idle, a rule left to the user.
// An input beat is parsed in the cycle it is accepted; its results pass
// through the queue into the output register. One byte is taken every
// cycle unless the queue is full; a byte with two results yields two
// output beats. A four-entry queue between the parser and the output
// register absorbs bursts and output stalls; in_tready drops only while
// that queue is full. Reset puts the parser at the start of a line, clears
// the invalid offset to zero and empties the queue and output register.
`default_nettype none

module hex_dec_text_line_parser #(
  parameter int MAX_LINE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_in
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [31:0] cfg_tdata,  // drop offset
  output logic        out_tvalid,
  input  logic        out_tready,
  // text_byte [7:0], line_offset [39:8], voice_number [71:40],
  // text_length [81:72], status [84:82], zero fill [87:85]
  output logic [hdtlp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic        out_tuser,  // kind
  output logic        out_tlast   // last
);
  import hdtlp_pkg::*;

  hdtlp_entry_t push_entry, head;
  logic         push, q_full, q_empty, pop;

  hdtlp_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  hdtlp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (head)
  );

  hdtlp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
